### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTTF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTTF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/bttf_pkg.sv
`timescale 1ns / 1ps

package bttf_pkg;

   // Field widths of the request, response and CSR port.
   localparam int ACT_W      = 2;
   localparam int CLS_W      = 4;
   localparam int TGT_W      = 32;
   localparam int MEAS_W     = 44;
   localparam int THR_W      = 13;
   localparam int STEP_W     = 7;
   localparam int CSR_W      = 13;

   // Measured bytes/s to MB/s.
   localparam int RATE_SHIFT = 20;
   localparam int RATE_W     = MEAS_W - RATE_SHIFT;

   localparam int BAND_HI_W  = 33;

   // Divide-by-100 unit: the product target * step is split into 8-bit digits.
   localparam int PROD_W     = TGT_W + STEP_W;
   localparam int DIV_DIGIT  = 8;
   localparam int DIV_STEPS  = (PROD_W + DIV_DIGIT - 1) / DIV_DIGIT;
   localparam int DIV_W      = DIV_STEPS * DIV_DIGIT;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int QUO_W      = 33;
   localparam int REM_W      = 7;
   localparam logic [REM_W:0] PCT_DEN = 8'd100;

   localparam logic [STEP_W-1:0] STEP_PCT_MAX = 7'd100;
   localparam logic [STEP_W-1:0] STEP_RESET   = 7'd10;
   localparam logic [THR_W-1:0]  LIMIT_RESET  = 13'd90;

   localparam logic [TGT_W-1:0]     U32_MAX  = '1;
   localparam logic [BAND_HI_W-1:0] HIGH_MAX = '1;
   localparam logic [THR_W-1:0]     THR_MAX  = '1;

   // At most this many writes leave one flush.
   localparam int MAX_OUT = 16;
   localparam int CNT_W   = $clog2(MAX_OUT + 1);

   typedef enum logic [ACT_W-1:0] {
      ACT_SET_TARGET,
      ACT_SAMPLE,
      ACT_FLUSH,
      ACT_RESET_THR
   } action_type;

   typedef enum logic {
      CSR_STEP_PERCENT,
      CSR_THROTTLE_LIMIT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_RESPOND,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [TGT_W-1:0]     target;
      logic [TGT_W-1:0]     band_low;
      logic [BAND_HI_W-1:0] band_high;
   } band_entry_type;

   localparam band_entry_type BAND_RESET = '{
      target:    U32_MAX,
      band_low:  U32_MAX,
      band_high: {1'b0, U32_MAX}
   };

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic             rem_nonzero;
   } div_result_type;

endpackage

### hw/rtl/bttf_ram.sv
`timescale 1ns / 1ps

module bttf_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bttf_div100.sv
`timescale 1ns / 1ps

module bttf_div100 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bttf_pkg::PROD_W-1:0]   dividend,
   output bttf_pkg::div_result_type      result
);

   import bttf_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic [DIV_W-1:0]     work_ff, work_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [REM_W:0]       trial;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // Restoring division by 100, one 8-bit digit per cycle. The remainder
   // stays below 100, so each bit step is an 8-bit compare and subtract.
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      trial   = '0;
      for (int k = 0; k < DIV_DIGIT; k++) begin
         trial   = {rem_in, work_in[DIV_W-1]};
         work_in = {work_in[DIV_W-2:0], 1'b0};
         if (trial >= PCT_DEN) begin
            rem_in     = REM_W'(trial - PCT_DEN);
            work_in[0] = 1'b1;
         end else begin
            rem_in = trial[REM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == DIV_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= DIV_W'(dividend);
         rem_ff  <= '0;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign result.done        = done_ff;
   assign result.quotient    = work_ff[QUO_W-1:0];
   assign result.rem_nonzero = |rem_ff;

endmodule

### hw/rtl/bandwidth_throttle_feedback_core.sv
`timescale 1ns / 1ps

// Per-class bandwidth throttle controller. Each class has a table entry with a
// target in MB/s, a low and a high band around it, a throttle level and a dirty
// mark. A set-target item stores a new target and derives the bands as
// target * (100 -/+ step_percent) / 100; a sample item converts a measured
// rate in bytes/s to MB/s and moves the throttle by one step when the rate
// leaves the band; a flush item returns one throttle write per dirty entry in
// class order (at most 16, the final one flagged last); a reset item zeroes
// every throttle and marks every entry dirty. Every item except a flush with
// dirty entries answers with a single result that carries no write. Targets
// and bands live in one synchronous RAM and throttles in a second; per-entry
// valid flags stand in for the reset values, so no clearing pass is needed
// after reset. One item is processed at a time: a sample passes through accept,
// RAM read and respond; a set target that changes the target also passes the
// 5-step divide-by-100 unit between read and respond, and one that does not
// skips it; a reset item and a flush with nothing dirty go from accept straight
// to respond; any other flush accepts, then steps past each clean entry and
// reads and emits each write in turn through the single throttle RAM read port.
// A stalled response channel holds the respond and emit steps. The next item may
// be accepted while the last result still waits in the output register.
module bandwidth_throttle_feedback_core #(
   parameter int NUM_CLASSES = 16
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bttf_pkg::ACT_W-1:0]        req_action,
   input  logic [bttf_pkg::CLS_W-1:0]        req_class_index,
   input  logic [bttf_pkg::TGT_W-1:0]        req_target_mbps,
   input  logic [bttf_pkg::MEAS_W-1:0]       req_measured_rate,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_has_write,
   output logic [bttf_pkg::CLS_W-1:0]        rsp_write_class,
   output logic [bttf_pkg::THR_W-1:0]        rsp_write_throttle,
   output logic                              rsp_last,

   input  logic                              csr_write_en,
   input  bttf_pkg::csr_index_type           csr_index,
   input  logic [bttf_pkg::CSR_W-1:0]        csr_wdata
);

   import bttf_pkg::*;

   localparam int IDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int BAND_W = $bits(band_entry_type);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUT - 1);

   // Control state.
   state_type            state_ff, state_in;
   logic [NUM_CLASSES-1:0] dirty_ff, dirty_in;
   logic [NUM_CLASSES-1:0] band_vld_ff, band_vld_in;
   logic [NUM_CLASSES-1:0] thr_vld_ff, thr_vld_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 out_vld_ff, out_vld_in;

   // Configuration.
   logic [STEP_W-1:0]    step_ff;
   logic [THR_W-1:0]     limit_ff;

   // Captured item.
   action_type           act_ff;
   logic [CLS_W-1:0]     cls_ff;
   logic [TGT_W-1:0]     tgt_ff;
   logic [RATE_W-1:0]    rate_ff;

   // Valid flags that travel with the RAM read data.
   logic                 band_rv_ff;
   logic                 thr_rv_ff;

   // Output register payload.
   logic                 out_has_write_ff, out_has_write_in;
   logic [CLS_W-1:0]     out_class_ff, out_class_in;
   logic [THR_W-1:0]     out_thr_ff, out_thr_in;
   logic                 out_last_ff, out_last_in;

   logic                 req_fire;
   action_type           req_act;
   logic                 in_range;
   logic                 req_rw;
   logic [IDX_W-1:0]     req_addr;
   logic [IDX_W-1:0]     cls_addr;
   logic                 out_free;
   logic                 out_load;

   logic                 band_rd_en;
   logic                 band_wr_en;
   band_entry_type       band_rd;
   band_entry_type       band_cur;
   band_entry_type       band_new;

   logic                 thr_rd_en;
   logic [IDX_W-1:0]     thr_rd_addr;
   logic                 thr_wr_en;
   logic [THR_W-1:0]     thr_rd;
   logic [THR_W-1:0]     thr_cur;
   logic [THR_W-1:0]     thr_new;
   logic [THR_W:0]       thr_sum;
   logic [THR_W-1:0]     step_thr;

   logic                 rise;
   logic                 fall;
   logic                 target_same;

   logic                 div_start;
   logic [PROD_W-1:0]    product;
   div_result_type       div_res;
   logic [TGT_W+1:0]     high_sum;
   logic [TGT_W-1:0]     low_sub;

   logic [NUM_CLASSES-1:0] dirty_above;
   logic                 flush_last;

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_act   = action_type'(req_action);
   assign in_range  = (int'(req_class_index) < NUM_CLASSES);
   // Set and sample read the entry; out-of-table classes are ignored.
   assign req_rw    = in_range && ((req_act == ACT_SET_TARGET) || (req_act == ACT_SAMPLE));
   assign req_addr  = IDX_W'(req_class_index);
   assign cls_addr  = IDX_W'(cls_ff);

   assign out_free  = !out_vld_ff || rsp_ready;

   // ------------------------------------------------------------------
   // Table memories
   // ------------------------------------------------------------------
   bttf_ram #(
      .WIDTH (BAND_W),
      .DEPTH (NUM_CLASSES)
   ) u_band_ram (
      .clock   (clock),
      .wr_en   (band_wr_en),
      .wr_addr (cls_addr),
      .wr_data (band_new),
      .rd_en   (band_rd_en),
      .rd_addr (req_addr),
      .rd_data (band_rd)
   );

   bttf_ram #(
      .WIDTH (THR_W),
      .DEPTH (NUM_CLASSES)
   ) u_thr_ram (
      .clock   (clock),
      .wr_en   (thr_wr_en),
      .wr_addr (cls_addr),
      .wr_data (thr_new),
      .rd_en   (thr_rd_en),
      .rd_addr (thr_rd_addr),
      .rd_data (thr_rd)
   );

   // An entry that was never written since reset reads as its reset value.
   // The throttle flags are also cleared by a reset item.
   assign band_cur = band_rv_ff ? band_rd : BAND_RESET;
   assign thr_cur  = thr_rv_ff ? thr_rd : '0;

   // ------------------------------------------------------------------
   // Sample datapath
   // ------------------------------------------------------------------
   assign step_thr = THR_W'(step_ff);
   assign rise     = (BAND_HI_W'(rate_ff) > band_cur.band_high) && (thr_cur < limit_ff);
   assign fall     = !rise && (TGT_W'(rate_ff) < band_cur.band_low) && (thr_cur != '0);
   assign thr_sum  = {1'b0, thr_cur} + {1'b0, step_thr};

   always_comb begin
      if (rise) begin
         thr_new = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];
      end else begin
         thr_new = (thr_cur >= step_thr) ? (thr_cur - step_thr) : '0;
      end
   end

   // ------------------------------------------------------------------
   // Set-target datapath
   // low  = target - ceil(target * step / 100)
   // high = target + floor(target * step / 100), saturated to 33 bits
   // ------------------------------------------------------------------
   assign target_same = (tgt_ff == band_cur.target);
   assign product     = PROD_W'(tgt_ff) * PROD_W'(step_ff);

   bttf_div100 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .result   (div_res)
   );

   // The sum needs 34 bits: a large step can push it past 2^33 - 1.
   assign high_sum = (TGT_W + 2)'(tgt_ff) + (TGT_W + 2)'(div_res.quotient);
   assign low_sub  = tgt_ff - TGT_W'(div_res.quotient) - TGT_W'(div_res.rem_nonzero);

   always_comb begin
      band_new.target    = tgt_ff;
      // A step of 100 percent or more pins the low band at zero.
      band_new.band_low  = (step_ff >= STEP_PCT_MAX) ? '0 : low_sub;
      band_new.band_high = high_sum[TGT_W+1] ? HIGH_MAX : high_sum[BAND_HI_W-1:0];
   end

   // ------------------------------------------------------------------
   // Flush scan: the current write is last when the 16th write is reached
   // or no dirty entry remains above the current class.
   // ------------------------------------------------------------------
   always_comb begin
      for (int j = 0; j < NUM_CLASSES; j++) begin
         dirty_above[j] = dirty_ff[j] && (j > int'(idx_ff));
      end
   end

   assign flush_last = (cnt_ff == CNT_LAST) || !(|dirty_above);

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_rw) begin
                  state_in = ST_READ;
               end else if ((req_act == ACT_FLUSH) && (|dirty_ff)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_READ: begin
            if ((act_ff == ACT_SET_TARGET) && !target_same) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (dirty_ff[idx_ff]) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = flush_last ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Outputs of the sequencer
   // ------------------------------------------------------------------
   always_comb begin
      band_rd_en       = 1'b0;
      band_wr_en       = 1'b0;
      thr_rd_en        = 1'b0;
      thr_rd_addr      = idx_ff;
      thr_wr_en        = 1'b0;
      div_start        = 1'b0;
      out_load         = 1'b0;
      out_has_write_in = 1'b0;
      out_class_in     = '0;
      out_thr_in       = '0;
      out_last_in      = 1'b1;
      dirty_in         = dirty_ff;
      band_vld_in      = band_vld_ff;
      thr_vld_in       = thr_vld_ff;
      idx_in           = idx_ff;
      cnt_in           = cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               band_rd_en  = req_rw;
               thr_rd_en   = req_rw;
               thr_rd_addr = req_addr;
               idx_in      = '0;
               cnt_in      = '0;
               if (req_act == ACT_RESET_THR) begin
                  thr_vld_in = '0;
                  dirty_in   = '1;
               end
            end
         end
         ST_READ: begin
            if (act_ff == ACT_SAMPLE) begin
               // A taken step marks the entry dirty even when the level holds.
               if (rise || fall) begin
                  thr_wr_en            = 1'b1;
                  thr_vld_in[cls_addr] = 1'b1;
                  dirty_in[cls_addr]   = 1'b1;
               end
            end else begin
               div_start = !target_same;
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               band_wr_en            = 1'b1;
               band_vld_in[cls_addr] = 1'b1;
            end
         end
         ST_RESPOND: begin
            out_load = out_free;
         end
         ST_SCAN: begin
            if (dirty_ff[idx_ff]) begin
               thr_rd_en = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load         = 1'b1;
               out_has_write_in = 1'b1;
               out_class_in     = CLS_W'(idx_ff);
               out_thr_in       = thr_cur;
               out_last_in      = flush_last;
               dirty_in[idx_ff] = 1'b0;
               cnt_in           = cnt_ff + 1'b1;
               if (!flush_last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign out_vld_in = out_load || (out_vld_ff && !rsp_ready);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         dirty_ff    <= '1;
         band_vld_ff <= '0;
         thr_vld_ff  <= '0;
         idx_ff      <= '0;
         cnt_ff      <= '0;
         out_vld_ff  <= 1'b0;
         step_ff     <= STEP_RESET;
         limit_ff    <= LIMIT_RESET;
      end else begin
         state_ff    <= state_in;
         dirty_ff    <= dirty_in;
         band_vld_ff <= band_vld_in;
         thr_vld_ff  <= thr_vld_in;
         idx_ff      <= idx_in;
         cnt_ff      <= cnt_in;
         out_vld_ff  <= out_vld_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_STEP_PERCENT:   step_ff  <= csr_wdata[STEP_W-1:0];
               CSR_THROTTLE_LIMIT: limit_ff <= csr_wdata[THR_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff  <= req_act;
         cls_ff  <= req_class_index;
         tgt_ff  <= req_target_mbps;
         rate_ff <= req_measured_rate[MEAS_W-1:RATE_SHIFT];
      end
      if (band_rd_en) begin
         band_rv_ff <= band_vld_ff[req_addr];
      end
      if (thr_rd_en) begin
         thr_rv_ff <= thr_vld_ff[thr_rd_addr];
      end
      if (out_load) begin
         out_has_write_ff <= out_has_write_in;
         out_class_ff     <= out_class_in;
         out_thr_ff       <= out_thr_in;
         out_last_ff      <= out_last_in;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_has_write      = out_has_write_ff;
   assign rsp_write_class    = out_class_ff;
   assign rsp_write_throttle = out_thr_ff;
   assign rsp_last           = out_last_ff;

endmodule

### hw/rtl/bttf_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bttf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_has_write,
   input logic [bttf_pkg::CLS_W-1:0]  rsp_write_class,
   input logic [bttf_pkg::THR_W-1:0]  rsp_write_throttle,
   input logic                        rsp_last
);

   // A stalled result keeps its contents.
   `BTTF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_has_write, rsp_write_class, rsp_write_throttle, rsp_last}), "result changed while stalled")

   // A result without a write is always the only result of its item.
   `BTTF_ASSERT_IMP(a_nowrite_last, clock, reset, rsp_valid && !rsp_has_write, rsp_last, "result without a write is not last")

   // A result without a write carries zero class and throttle.
   `BTTF_ASSERT_IMP(a_nowrite_zero, clock, reset, rsp_valid && !rsp_has_write, (rsp_write_class == '0) && (rsp_write_throttle == '0), "result without a write has nonzero fields")

   // Items are processed one at a time, so an accept is never followed by ready.
   `BTTF_ASSERT_NXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "ready high right after an accepted item")

endmodule

bind bandwidth_throttle_feedback_core bttf_checker u_bttf_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bttf_pkg::*;

   localparam int NCLS            = 16;
   localparam int THR_W1          = THR_W + 1;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 36;
   localparam int SATURATE_RUN    = 72;
   localparam int SETTLE_CYCLES   = 24;
   localparam int DRAIN_CYCLES    = 60;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIR_ROWS        = 20;

   // One control item as it travels on the request channel.
   typedef struct packed {
      action_type        action;
      logic [CLS_W-1:0]  cls;
      logic [TGT_W-1:0]  target;
      logic [MEAS_W-1:0] meas;
   } ctl_item_type;

   // One result on the response channel.
   typedef struct packed {
      logic             has_write;
      logic [CLS_W-1:0] cls;
      logic [THR_W-1:0] thr;
      logic             last;
   } thr_write_type;

   // A directed row carries its item and, where the answer is obvious, the single
   // result that must come back.
   typedef struct packed {
      ctl_item_type  item;
      logic          typed;
      thr_write_type want;
   } dir_row_type;

   // The plain acknowledge: no write, last set.
   localparam thr_write_type NO_WRITE_ACK = '{1'b0, 4'd0, 13'd0, 1'b1};
   localparam thr_write_type CLS5_AT_10   = '{1'b1, 4'd5, 13'd10, 1'b1};

   // The directed part. With the reset step of 10 percent a target of 100 MB/s
   // gives a band from 90 to 110, so 200 MB/s lifts class 5 to a throttle of 10.
   // Setting class 15 to all ones matches its reset target and changes nothing,
   // while a target of zero makes any nonzero rate count as too fast.
   localparam dir_row_type DIRECTED [0:DIR_ROWS-1] = '{
      '{'{ACT_FLUSH,      4'd0,  32'd0,          44'd0},           1'b0, NO_WRITE_ACK},
      '{'{ACT_FLUSH,      4'd0,  32'd0,          44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_SAMPLE,     4'd0,  32'd0,          44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_SET_TARGET, 4'd5,  32'd100,        44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_SAMPLE,     4'd5,  32'd0,          44'h000_0C80_0000}, 1'b1, NO_WRITE_ACK},
      '{'{ACT_FLUSH,      4'd0,  32'd0,          44'd0},           1'b1, CLS5_AT_10},
      '{'{ACT_SET_TARGET, 4'd5,  32'd100,        44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_SAMPLE,     4'd5,  32'd0,          44'hFFF_FFFF_FFFF}, 1'b1, NO_WRITE_ACK},
      '{'{ACT_SAMPLE,     4'd5,  32'hFFFF_FFFF,  44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_SET_TARGET, 4'd15, 32'hFFFF_FFFF,  44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_SET_TARGET, 4'd15, 32'd0,          44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_SAMPLE,     4'd15, 32'd0,          44'h000_0010_0000}, 1'b1, NO_WRITE_ACK},
      '{'{ACT_SAMPLE,     4'd15, 32'd0,          44'h000_000F_FFFF}, 1'b1, NO_WRITE_ACK},
      '{'{ACT_FLUSH,      4'd0,  32'd0,          44'd0},           1'b0, NO_WRITE_ACK},
      '{'{ACT_RESET_THR,  4'd0,  32'd0,          44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_FLUSH,      4'd0,  32'd0,          44'd0},           1'b0, NO_WRITE_ACK},
      '{'{ACT_SET_TARGET, 4'd0,  32'hFFFF_FFFE,  44'd0},           1'b1, NO_WRITE_ACK},
      '{'{ACT_SAMPLE,     4'd0,  32'd0,          44'hFFF_FFFF_FFFF}, 1'b1, NO_WRITE_ACK},
      '{'{ACT_SAMPLE,     4'd9,  32'd0,          44'hA5A_5A5A_5A5A}, 1'b0, NO_WRITE_ACK},
      '{'{ACT_FLUSH,      4'd0,  32'd0,          44'd0},           1'b1, NO_WRITE_ACK}
   };

   // Clock and reset. Every input of the block has a known value from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [ACT_W-1:0]      req_action        = '0;
   logic [CLS_W-1:0]      req_class_index   = '0;
   logic [TGT_W-1:0]      req_target_mbps   = '0;
   logic [MEAS_W-1:0]     req_measured_rate = '0;

   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic                  rsp_has_write;
   logic [CLS_W-1:0]      rsp_write_class;
   logic [THR_W-1:0]      rsp_write_throttle;
   logic                  rsp_last;

   logic                  csr_write_en      = 1'b0;
   csr_index_type         csr_index         = CSR_STEP_PERCENT;
   logic [CSR_W-1:0]      csr_wdata         = '0;

   bandwidth_throttle_feedback_core #(
      .NUM_CLASSES (NCLS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_class_index    (req_class_index),
      .req_target_mbps    (req_target_mbps),
      .req_measured_rate  (req_measured_rate),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_has_write      (rsp_has_write),
      .rsp_write_class    (rsp_write_class),
      .rsp_write_throttle (rsp_write_throttle),
      .rsp_last           (rsp_last),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Our own copy of the throttle table and the two registers. It is advanced
   // at the clock edge where the block accepts an item, so it always describes
   // the state the block should reach once that item is done.
   logic [TGT_W-1:0]     tgt_tab  [NCLS];
   logic [TGT_W-1:0]     low_tab  [NCLS];
   logic [BAND_HI_W-1:0] high_tab [NCLS];
   logic [THR_W-1:0]     thr_tab  [NCLS];
   logic                 dirty_tab[NCLS];
   logic [STEP_W-1:0]    cfg_step;
   logic [THR_W-1:0]     cfg_limit;

   // Results the block still owes us, oldest first.
   thr_write_type owed_results[$];

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int mismatches      = 0;
   int results_seen    = 0;
   int writes_seen     = 0;
   int cycle_count     = 0;
   int action_count [4] = '{0, 0, 0, 0};

   function automatic void reset_throttle_table();
      int i;
      cfg_step  = STEP_RESET;
      cfg_limit = LIMIT_RESET;
      for (i = 0; i < NCLS; i++) begin
         tgt_tab[i]   = BAND_RESET.target;
         low_tab[i]   = BAND_RESET.band_low;
         high_tab[i]  = BAND_RESET.band_high;
         thr_tab[i]   = '0;
         dirty_tab[i] = 1'b1;
      end
   endfunction

   // Apply one item to the table and work out the results it must produce.
   function automatic void advance_throttle_table(input ctl_item_type it,
                                                  output thr_write_type res [NCLS],
                                                  output int n);
      logic [63:0]       low_pct;
      logic [63:0]       high_val;
      logic [RATE_W-1:0] rate_mb;
      logic [THR_W1-1:0] thr_next;
      int i;
      n = 0;
      case (it.action)
         ACT_SET_TARGET: begin
            // An unchanged target leaves the bands exactly as they were.
            if (it.target != tgt_tab[it.cls]) begin
               low_pct  = (cfg_step >= STEP_PCT_MAX) ? 64'd0 : 64'd100 - 64'(cfg_step);
               high_val = 64'(it.target) * (64'd100 + 64'(cfg_step)) / 64'd100;
               tgt_tab[it.cls]  = it.target;
               low_tab[it.cls]  = TGT_W'(64'(it.target) * low_pct / 64'd100);
               high_tab[it.cls] = (high_val > 64'(HIGH_MAX)) ? HIGH_MAX
                                                             : BAND_HI_W'(high_val);
            end
         end
         ACT_SAMPLE: begin
            rate_mb = it.meas[MEAS_W-1:RATE_SHIFT];
            if (BAND_HI_W'(rate_mb) > high_tab[it.cls] && thr_tab[it.cls] < cfg_limit) begin
               thr_next = {1'b0, thr_tab[it.cls]} + THR_W1'(cfg_step);
               thr_tab[it.cls]   = (thr_next > THR_W1'(THR_MAX)) ? THR_MAX
                                                                 : thr_next[THR_W-1:0];
               dirty_tab[it.cls] = 1'b1;
            end else if (TGT_W'(rate_mb) < low_tab[it.cls] && thr_tab[it.cls] != '0) begin
               thr_tab[it.cls]   = (thr_tab[it.cls] >= THR_W'(cfg_step))
                                   ? thr_tab[it.cls] - THR_W'(cfg_step) : '0;
               dirty_tab[it.cls] = 1'b1;
            end
         end
         ACT_FLUSH: begin
            for (i = 0; i < NCLS && n < MAX_OUT; i++) begin
               if (dirty_tab[i]) begin
                  dirty_tab[i] = 1'b0;
                  res[n] = '{1'b1, CLS_W'(i), thr_tab[i], 1'b0};
                  n++;
               end
            end
         end
         default: begin
            for (i = 0; i < NCLS; i++) begin
               thr_tab[i]   = '0;
               dirty_tab[i] = 1'b1;
            end
         end
      endcase
      if (n == 0) begin
         res[0] = NO_WRITE_ACK;
         n = 1;
      end else begin
         res[n-1].last = 1'b1;
      end
   endfunction

   // Random items are shaped around the current table: targets are mostly small
   // enough that a 24-bit rate can leave the band on either side, and sampled
   // rates cluster around and on the band edges of the chosen class.
   function automatic ctl_item_type random_control_item();
      ctl_item_type      it;
      int unsigned       pick;
      int unsigned       sel;
      logic [63:0]       span;
      logic [63:0]       band_edge;
      logic [RATE_W-1:0] mb;
      pick = $urandom_range(99);
      sel  = $urandom_range(9);
      it.action = (pick < 48) ? ACT_SAMPLE : (pick < 70) ? ACT_SET_TARGET :
                  (pick < 93) ? ACT_FLUSH : ACT_RESET_THR;
      if ($urandom_range(4) == 0)
         it.cls = $urandom_range(1) ? CLS_W'(NCLS - 1) : '0;
      else
         it.cls = CLS_W'($urandom_range(NCLS - 1));
      it.target = $urandom;
      it.meas   = MEAS_W'({$urandom, $urandom});
      if (it.action == ACT_SET_TARGET) begin
         if (sel < 6)
            it.target = $urandom_range(4000);
         else if (sel == 6)
            it.target = tgt_tab[it.cls];
         else if (sel == 7)
            it.target = $urandom >> $urandom_range(31);
         else if (sel == 8)
            it.target = $urandom_range(1) ? '1 : '0;
      end else if (it.action == ACT_SAMPLE && sel < 9) begin
         if (sel < 6) begin
            span = 64'(high_tab[it.cls]) + 64'(high_tab[it.cls] >> 3) + 64'd2;
            if (span > 64'hFF_FFFF)
               span = 64'hFF_FFFF;
            mb = RATE_W'($urandom_range(32'(span)));
         end else if (sel < 8) begin
            case ($urandom_range(3))
               0:       band_edge = 64'(low_tab[it.cls]) - 64'd1;
               1:       band_edge = 64'(low_tab[it.cls]);
               2:       band_edge = 64'(high_tab[it.cls]);
               default: band_edge = 64'(high_tab[it.cls]) + 64'd1;
            endcase
            if (band_edge > 64'hFF_FFFF)
               band_edge = 64'hFF_FFFF;
            mb = RATE_W'(band_edge);
         end else begin
            mb = $urandom_range(1) ? '1 : '0;
         end
         it.meas = {mb, 20'($urandom)};
      end
      return it;
   endfunction

   // Present one item and hold it until the block takes it. Valid is only
   // lowered when the sender really idles, so back-to-back items never see
   // valid dropped and raised within the same time step. With hold set, the
   // sender waits until every owed result has come back.
   task automatic offer_item(input ctl_item_type it, input bit typed,
                             input thr_write_type want, input bit hold);
      thr_write_type res [NCLS];
      int n;
      int k;
      @(negedge clock);
      if (hold || $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(negedge clock);
         while (hold ? owed_results.size() != 0 : $urandom_range(99) < sender_idle_pct);
      end
      req_valid         <= 1'b1;
      req_action        <= it.action;
      req_class_index   <= it.cls;
      req_target_mbps   <= it.target;
      req_measured_rate <= it.meas;
      do
         @(posedge clock);
      while (!req_ready);
      advance_throttle_table(it, res, n);
      if (typed) begin
         owed_results.push_back(want);
      end else begin
         for (k = 0; k < n; k++)
            owed_results.push_back(res[k]);
      end
      action_count[it.action]++;
   endtask

   // Registers are only written while the block is idle: nothing owed, plus a
   // short settling pause for the last response to leave the output stage.
   task automatic settle_and_configure(input logic [STEP_W-1:0] step,
                                       input logic [THR_W-1:0] limit);
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_STEP_PERCENT;
      csr_wdata    <= CSR_W'(step);
      @(negedge clock);
      csr_index    <= CSR_THROTTLE_LIMIT;
      csr_wdata    <= CSR_W'(limit);
      @(negedge clock);
      csr_write_en <= 1'b0;
      cfg_step  = step;
      cfg_limit = limit;
   endtask

   function automatic void report_mismatch(input string what, input thr_write_type want,
                                           input thr_write_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s: expected write=%0d class=%0d throttle=%0d last=%0d, got write=%0d class=%0d throttle=%0d last=%0d",
                  $time, what, want.has_write, want.cls, want.thr, want.last,
                  got.has_write, got.cls, got.thr, got.last);
   endfunction

   // The receiver stalls at random; the chance is set per phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every accepted result is compared field by field with the oldest one owed.
   always @(posedge clock) begin : check_results
      thr_write_type want;
      thr_write_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_has_write, rsp_write_class, rsp_write_throttle, rsp_last};
         results_seen++;
         if (got.has_write === 1'b1)
            writes_seen++;
         if (owed_results.size() == 0) begin
            report_mismatch("result with nothing owed", '0, got);
         end else begin
            want = owed_results.pop_front();
            if (got.has_write !== want.has_write || got.cls !== want.cls ||
                got.thr !== want.thr || got.last !== want.last)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   // Watchdog. The limit is far above the slowest legal run: every item a full
   // flush, every result held by the longest receiver stall.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results still owed",
                  cycle_count, owed_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : run_sequence
      int i;
      int ph;
      int k;
      logic [STEP_W-1:0] step;
      logic [THR_W-1:0]  limit;
      ctl_item_type      burst;

      reset_throttle_table();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed rows run with the reset settings and no idling on either side.
      for (i = 0; i < DIR_ROWS; i++)
         offer_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want, 1'b0);

      // Random phases. Each one writes both registers, including the extremes
      // (a zero step, steps at and above 100 percent, limits of 1 and 8191),
      // and walks through the four idling modes.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       begin step = 7'd10;  limit = 13'd90;   end
            1:       begin step = 7'd1;   limit = 13'd4096; end
            2:       begin step = 7'd99;  limit = 13'd1;    end
            3:       begin step = 7'd0;   limit = 13'd50;   end
            4:       begin step = 7'd127; limit = 13'd8191; end
            5:       begin step = 7'd100; limit = 13'd8191; end
            6:       begin
               step  = STEP_W'($urandom_range(98, 2));
               limit = THR_W'($urandom_range(4095, 2));
            end
            default: begin step = 7'd50;  limit = 13'd4096; end
         endcase
         settle_and_configure(step, limit);
         case (ph % 4)
            0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin sender_idle_pct = 55; rsp_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rsp_stall_pct = 55; end
            default: begin sender_idle_pct = 31; rsp_stall_pct = 31; end
         endcase

         // With the largest step and limit, drive one class hard enough that
         // its throttle climbs into saturation at the top of its range.
         if (ph == 4) begin
            burst = '{ACT_SET_TARGET, 4'd3, 32'd0, 44'd0};
            offer_item(burst, 1'b0, NO_WRITE_ACK, 1'b0);
            for (k = 0; k < SATURATE_RUN; k++) begin
               burst = '{ACT_SAMPLE, 4'd3, 32'd0,
                         {RATE_W'($urandom_range(24'hFF_FFFF, 1)), 20'($urandom)}};
               offer_item(burst, 1'b0, NO_WRITE_ACK, 1'b0);
            end
         end

         for (k = 0; k < ITEMS_PER_PHASE; k++)
            offer_item(random_control_item(), 1'b0, NO_WRITE_ACK, ph == 2 && k == 24);
      end

      // Drain: wait for every owed result, then give stray results time to show.
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Items sent: %0d set target, %0d sample, %0d flush, %0d throttle reset",
               action_count[ACT_SET_TARGET], action_count[ACT_SAMPLE],
               action_count[ACT_FLUSH], action_count[ACT_RESET_THR]);
      $display("Results checked: %0d, of which %0d throttle writes; %0d mismatches",
               results_seen, writes_seen, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
